// File: design/woh_pkg.sv
// Package for the windowed ordinal histogram: payload structs, item kinds,
// configuration register indexes and controller/datapath command structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package woh_pkg;

  // Item kinds carried in the request.
  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Configuration register indexes.
  localparam logic CFG_RANGE_START = 1'b0;
  localparam logic CFG_RANGE_END   = 1'b1;

  // Field widths.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ORD_W    = 31;
  localparam int unsigned SEL_W    = 12;
  localparam int unsigned OCOUNT_W = 32;
  localparam int unsigned START_W  = 32;
  localparam int unsigned END_W    = 31;

  // Input request.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ORD_W-1:0]  term_ordinal;
    logic [SEL_W-1:0]  bin_select;
  } in_req_t;

  // Output response.
  typedef struct packed {
    logic [SEL_W-1:0]    bin_number;
    logic [OCOUNT_W-1:0] bin_count;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the accepted request
    logic clear_step;  // zero one entry of the post-reset clearing pass
    logic access;      // compute the bin address and read the memory
    logic commit;      // write back or load the response register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              clear_last;   // clearing pass is at its final entry
    logic [KIND_W-1:0] kind;         // kind of the request in flight
    logic              out_blocked;  // response register full and not taken
  } ctrl_sts_t;

endpackage

`default_nettype wire

// File: design/windowed_ordinal_histogram.sv
// Windowed ordinal histogram: counts term ordinals into bins, reads and clears bins.
// Each request passes through accept, access (memory read) and update (write back)
// steps, and no new request is accepted until it finishes; a read response is
// registered in the update step, and a read waits in that step while the previous
// response is still untaken. After reset a clearing pass zeroes all BINS entries,
// during which no request is accepted; configuration is always taken.
`timescale 1ns / 1ps
`default_nettype none

module windowed_ordinal_histogram #(
  parameter int unsigned BINS        = 4096,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire woh_pkg::in_req_t            in_req_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output woh_pkg::out_rsp_t                out_rsp_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_index_i,
  input  wire logic [woh_pkg::START_W-1:0] cfg_data_i
);

  woh_pkg::ctrl_cmd_t cmd;
  woh_pkg::ctrl_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Controller.
  woh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  woh_dp #(
    .BINS        (BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // Only one controller command is active in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_item, cmd.clear_step, cmd.access, cmd.commit}))
    else $error("controller issued overlapping commands");

  // An accepted request is followed by its access step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (cmd.access && !in_ready_o))
    else $error("accepted request not followed by access step");

  // A read never completes over an untaken response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit && (sts.kind == woh_pkg::KIND_READ)) |-> !sts.out_blocked)
    else $error("read response overwrote a pending response");

endmodule

`default_nettype wire

// File: design/woh_ctrl.sv
// Controller for the windowed ordinal histogram: clearing pass after reset,
// then one request at a time through access and update steps.
// Depends on woh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module woh_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire woh_pkg::ctrl_sts_t sts_i,
  output woh_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_ACCESS = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   read_stall;

  // A read cannot finish while the response register still holds an untaken response.
  assign read_stall = (sts_i.kind == woh_pkg::KIND_READ) && sts_i.out_blocked;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!read_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: design/woh_dp.sv
// Datapath for the windowed ordinal histogram: window registers, bin address
// computation, the bin counter memory and the response register.
// Depends on woh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module woh_dp #(
  parameter int unsigned BINS        = 4096,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire woh_pkg::in_req_t                    in_req_i,
  input  wire logic                                cfg_valid_i,
  input  wire logic                                cfg_index_i,
  input  wire logic [woh_pkg::START_W-1:0]         cfg_data_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output woh_pkg::out_rsp_t                        out_rsp_o,
  input  wire woh_pkg::ctrl_cmd_t                  cmd_i,
  output woh_pkg::ctrl_sts_t                       sts_o
);

  localparam int unsigned AW = $clog2(BINS);

  logic [woh_pkg::START_W-1:0] range_start_q;
  logic [woh_pkg::END_W-1:0]   range_end_q;
  woh_pkg::in_req_t            item_q;
  logic [AW-1:0]               clr_cnt_q;
  logic [AW-1:0]               addr_q, addr_d;
  logic                        hit_q, hit_d;
  logic [COUNT_WIDTH-1:0]      rdata_q;
  logic                        out_valid_q, out_valid_d;
  woh_pkg::out_rsp_t           out_rsp_q;
  logic [COUNT_WIDTH-1:0]      mem_q [BINS];

  logic signed [33:0]          bin;
  logic                        count_hit;
  logic [31:0]                 sel_ext;
  logic                        sel_hit;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [COUNT_WIDTH-1:0]      mem_wdata;
  logic [COUNT_WIDTH-1:0]      count_inc;
  logic [63:0]                 count_wide;
  logic [woh_pkg::OCOUNT_W-1:0] count_out;

  // Window registers, written through the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= '1;
      range_end_q   <= woh_pkg::END_W'(4095);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        woh_pkg::CFG_RANGE_START: range_start_q <= cfg_data_i;
        woh_pkg::CFG_RANGE_END:   range_end_q   <= cfg_data_i[woh_pkg::END_W-1:0];
        default:                  range_end_q   <= range_end_q;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_req_i;
    end
  end

  // Bin of a counted ordinal; it lies below range_end - range_start exactly
  // when the ordinal does not exceed range_end.
  assign bin = $signed({3'b000, item_q.term_ordinal})
             - $signed({{2{range_start_q[31]}}, range_start_q}) - 34'sd1;
  assign count_hit = !bin[33] && (item_q.term_ordinal <= range_end_q)
                   && (bin < $signed(34'(BINS)));
  assign sel_ext   = 32'(item_q.bin_select);
  assign sel_hit   = sel_ext < 32'(BINS);

  // Address and hit for the request in flight.
  always_comb begin
    addr_d = sel_ext[AW-1:0];
    hit_d  = 1'b0;
    case (item_q.kind) inside
      woh_pkg::KIND_COUNT: begin
        addr_d = bin[AW-1:0];
        hit_d  = count_hit;
      end
      woh_pkg::KIND_READ, woh_pkg::KIND_CLEAR: begin
        hit_d = sel_hit;
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      addr_q <= addr_d;
      hit_q  <= hit_d;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // Saturating increment of the counter that was read.
  assign count_inc = (rdata_q == '1) ? rdata_q : rdata_q + COUNT_WIDTH'(1);

  // Memory write port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    if (cmd_i.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
    end else if (cmd_i.commit && hit_q) begin
      case (item_q.kind)
        woh_pkg::KIND_COUNT: begin
          mem_we    = 1'b1;
          mem_wdata = count_inc;
        end
        woh_pkg::KIND_CLEAR: begin
          mem_we = 1'b1;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // Bin counter memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.access) begin
      rdata_q <= mem_q[addr_d];
    end
  end

  // Response count, saturated to the output width; bins outside the store read zero.
  assign count_wide = 64'(rdata_q);
  assign count_out  = !hit_q ? '0
                    : (count_wide[63:32] != '0) ? '1 : count_wide[31:0];

  // Response register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit && (item_q.kind == woh_pkg::KIND_READ)) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (item_q.kind == woh_pkg::KIND_READ)) begin
      out_rsp_q.bin_number <= item_q.bin_select;
      out_rsp_q.bin_count  <= count_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Status back to the controller.
  assign sts_o.clear_last  = (clr_cnt_q == AW'(BINS - 1));
  assign sts_o.kind        = item_q.kind;
  assign sts_o.out_blocked = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire
